### sv/protection_mcu_command_port_core_assert.svh
// Assertion macros used by the command port controller.
`ifndef PROTECTION_MCU_COMMAND_PORT_CORE_ASSERT_SVH
`define PROTECTION_MCU_COMMAND_PORT_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PMCP_ASSERT_NOW(label, clk_s, rstn_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("pmcp: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PMCP_ASSERT_NEXT(label, clk_s, rstn_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("pmcp: next-cycle check failed");

`endif

### sv/pmcp_pkg.sv
`timescale 1ns / 1ps

package pmcp_pkg;

  // Table geometry and default wrap depth.
  localparam int TABLE_LEN       = 16;
  localparam int PTR_W           = 4;
  localparam int TABLE_DEPTH_DEF = 16;

  // Command bytes understood in idle mode.
  localparam logic [7:0] CMD_TABLE1 = 8'd1;
  localparam logic [7:0] CMD_TABLE2 = 8'd2;
  localparam logic [7:0] CMD_TABLE3 = 8'd3;
  localparam logic [7:0] CMD_DIVIDE = 8'd4;
  localparam logic [7:0] CMD_NEXT   = 8'd6;

  // Fixed answers.
  localparam logic [7:0] ANS_DIVIDE   = 8'd4;
  localparam logic [7:0] ANS_DIV_ZERO = 8'hff;

  // Divide sequence phases.
  localparam logic [1:0] PH_IDLE     = 2'd0;
  localparam logic [1:0] PH_DIVIDEND = 2'd1;
  localparam logic [1:0] PH_DIVISOR  = 2'd2;

  // Access kinds.
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  // Table selection codes.
  localparam logic [1:0] SEL_NONE = 2'd0;

  typedef logic [7:0] row_t [TABLE_LEN];

  // World version tables.
  localparam row_t W_T1 = '{8'h05, 8'h03, 8'h02, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                            8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
  localparam row_t W_T2 = '{8'h8e, 8'h42, 8'had, 8'h58, 8'hec, 8'h85, 8'hdd, 8'h4c,
                            8'had, 8'h9f, 8'h00, 8'h4c, 8'h7e, 8'h42, 8'ha2, 8'hff};
  localparam row_t W_T3 = '{8'hbd, 8'h73, 8'h80, 8'hbd, 8'h73, 8'ha7, 8'hbd, 8'h73,
                            8'he0, 8'h7e, 8'h72, 8'h56, 8'hff, 8'hff, 8'hff, 8'hff};
  // Japanese version tables.
  localparam row_t J_T1 = '{8'h05, 8'h03, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                            8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
  localparam row_t J_T2 = '{8'h8e, 8'h42, 8'hb2, 8'h58, 8'hec, 8'h85, 8'hdd, 8'h4c,
                            8'had, 8'h9f, 8'h00, 8'h4c, 8'h7e, 8'h42, 8'ha7, 8'hff};
  localparam row_t J_T3 = '{8'hbd, 8'h71, 8'hc8, 8'hbd, 8'h71, 8'hef, 8'hbd, 8'h72,
                            8'h28, 8'h7e, 8'h70, 8'h9e, 8'hff, 8'hff, 8'hff, 8'hff};

  // Controller to datapath commands.
  typedef struct packed {
    logic latch;
    logic apply;
    logic div_start;
    logic div_step;
    logic out_load;
  } pmcp_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic need_div;
    logic div_last;
  } pmcp_stat_t;

  // Looks up one table entry; an unselected table reads as zero.
  function automatic logic [7:0] table_entry(input logic region, input logic [1:0] sel,
                                             input logic [PTR_W-1:0] idx);
    logic [7:0] v;
    case ({region, sel})
      3'b001:  v = W_T1[idx];
      3'b010:  v = W_T2[idx];
      3'b011:  v = W_T3[idx];
      3'b101:  v = J_T1[idx];
      3'b110:  v = J_T2[idx];
      3'b111:  v = J_T3[idx];
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

### sv/pmcp_in_if.sv
`timescale 1ns / 1ps

// Host access channel.
interface pmcp_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] write_byte;

  modport source (output valid, kind, write_byte, input ready);
  modport sink (input valid, kind, write_byte, output ready);
endinterface

### sv/pmcp_out_if.sv
`timescale 1ns / 1ps

// Answer channel.
interface pmcp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] answer_byte;
  logic       irq_request;

  modport source (output valid, answer_byte, irq_request, input ready);
  modport sink (input valid, answer_byte, irq_request, output ready);
endinterface

### sv/pmcp_cfg_if.sv
`timescale 1ns / 1ps

// Region register write channel.
interface pmcp_cfg_if;
  logic valid;
  logic ready;
  logic region_variant;

  modport source (output valid, region_variant, input ready);
  modport sink (input valid, region_variant, output ready);
endinterface

### sv/pmcp_ctrl.sv
`timescale 1ns / 1ps
`include "protection_mcu_command_port_core_assert.svh"

module pmcp_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  pmcp_pkg::pmcp_stat_t stat,
  output pmcp_pkg::pmcp_cmd_t  cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  // Sequencing of one item: take it, update state or divide, then hand it out.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (stat.need_div) begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_DIV;
        end else begin
          cmd.apply = 1'b1;
          state_nxt = ST_DONE;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Output register occupancy.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `PMCP_ASSERT_NEXT(a_accept_exec, clk, rst_n, in_valid && in_ready, state_r == ST_EXEC)
  `PMCP_ASSERT_NEXT(a_div_entry, clk, rst_n, (state_r == ST_EXEC) && stat.need_div, state_r == ST_DIV)
  `PMCP_ASSERT_NOW(a_load_free, clk, rst_n, cmd.out_load, !out_valid_r || out_ready)

endmodule

### sv/pmcp_dp.sv
`timescale 1ns / 1ps

module pmcp_dp #(
  parameter int TABLE_DEPTH = pmcp_pkg::TABLE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pmcp_pkg::pmcp_cmd_t  cmd,
  output pmcp_pkg::pmcp_stat_t stat,
  input  logic                 in_kind,
  input  logic [7:0]           in_write_byte,
  input  logic                 cfg_we,
  input  logic                 cfg_region,
  output logic [7:0]           out_answer_byte,
  output logic                 out_irq_request
);

  localparam int PW = pmcp_pkg::PTR_W;
  localparam logic [PW:0] DEPTH = (PW + 1)'(TABLE_DEPTH);

  logic          region_r;
  logic [1:0]    phase_r, phase_nxt;
  logic [1:0]    sel_r, sel_nxt;
  logic [PW-1:0] ptr_r, ptr_nxt;
  logic [7:0]    dividend_r, dividend_nxt;
  logic [7:0]    answer_r, answer_nxt;
  logic          kind_r;
  logic [7:0]    data_r;
  logic [7:0]    rem_r, quo_r;
  logic [2:0]    cnt_r;
  logic [7:0]    out_answer_r;
  logic          out_irq_r;

  logic          is_sel_cmd;
  logic [1:0]    look_sel;
  logic [PW-1:0] look_idx;
  logic [7:0]    look_val;
  logic [PW:0]   idx_inc;
  logic [PW-1:0] idx_next;
  logic [8:0]    trial;
  logic          trial_ge;
  logic [7:0]    rem_step, quo_step;

  assign out_answer_byte = out_answer_r;
  assign out_irq_request = out_irq_r;

  assign stat.need_div = (kind_r == pmcp_pkg::KIND_WRITE) && (phase_r == pmcp_pkg::PH_DIVISOR)
                         && (data_r != 8'd0);
  assign stat.div_last = (cnt_r == 3'd7);

  // Table lookup: a select command restarts at entry zero, next-entry uses the pointer.
  assign is_sel_cmd = (data_r == pmcp_pkg::CMD_TABLE1) || (data_r == pmcp_pkg::CMD_TABLE2)
                      || (data_r == pmcp_pkg::CMD_TABLE3);
  assign look_sel   = is_sel_cmd ? data_r[1:0] : sel_r;
  assign look_idx   = is_sel_cmd ? '0 : ptr_r;
  assign look_val   = pmcp_pkg::table_entry(region_r, look_sel, look_idx);
  assign idx_inc    = {1'b0, look_idx} + (PW + 1)'(1);
  assign idx_next   = (idx_inc >= DEPTH) ? '0 : idx_inc[PW-1:0];

  // One restoring division step per cycle.
  assign trial    = {rem_r, quo_r[7]};
  assign trial_ge = (trial >= {1'b0, data_r});
  assign rem_step = trial_ge ? 8'(trial - {1'b0, data_r}) : trial[7:0];
  assign quo_step = {quo_r[6:0], trial_ge};

  // Command and parameter handling for one write, plus divide start and quotient capture.
  always_comb begin
    phase_nxt    = phase_r;
    sel_nxt      = sel_r;
    ptr_nxt      = ptr_r;
    dividend_nxt = dividend_r;
    answer_nxt   = answer_r;
    if (cmd.apply && (kind_r == pmcp_pkg::KIND_WRITE)) begin
      case (phase_r)
        pmcp_pkg::PH_DIVIDEND: begin
          phase_nxt    = pmcp_pkg::PH_DIVISOR;
          dividend_nxt = data_r;
          answer_nxt   = data_r;
        end
        pmcp_pkg::PH_DIVISOR: begin
          // Only a zero divisor reaches here; others go through the divider.
          phase_nxt  = pmcp_pkg::PH_IDLE;
          answer_nxt = pmcp_pkg::ANS_DIV_ZERO;
        end
        default: begin
          phase_nxt = pmcp_pkg::PH_IDLE;
          if (is_sel_cmd) begin
            sel_nxt    = data_r[1:0];
            answer_nxt = look_val;
            ptr_nxt    = idx_next;
          end else if (data_r == pmcp_pkg::CMD_DIVIDE) begin
            phase_nxt  = pmcp_pkg::PH_DIVIDEND;
            answer_nxt = pmcp_pkg::ANS_DIVIDE;
          end else if ((data_r == pmcp_pkg::CMD_NEXT) && (sel_r != pmcp_pkg::SEL_NONE)) begin
            answer_nxt = look_val;
            ptr_nxt    = idx_next;
          end
        end
      endcase
    end else if (cmd.div_start) begin
      phase_nxt = pmcp_pkg::PH_IDLE;
    end else if (cmd.div_step && stat.div_last) begin
      answer_nxt = quo_step;
    end
  end

  // Architectural state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      region_r   <= 1'b0;
      phase_r    <= pmcp_pkg::PH_IDLE;
      sel_r      <= pmcp_pkg::SEL_NONE;
      ptr_r      <= '0;
      dividend_r <= 8'd0;
      answer_r   <= 8'd0;
    end else begin
      if (cfg_we) begin
        region_r <= cfg_region;
      end
      phase_r    <= phase_nxt;
      sel_r      <= sel_nxt;
      ptr_r      <= ptr_nxt;
      dividend_r <= dividend_nxt;
      answer_r   <= answer_nxt;
    end
  end

  // Item capture, divider and output payload.
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      kind_r <= in_kind;
      data_r <= in_write_byte;
    end
    if (cmd.div_start) begin
      rem_r <= 8'd0;
      quo_r <= dividend_r;
      cnt_r <= 3'd0;
    end else if (cmd.div_step) begin
      rem_r <= rem_step;
      quo_r <= quo_step;
      cnt_r <= cnt_r + 3'd1;
    end
    if (cmd.out_load) begin
      out_answer_r <= answer_r;
      out_irq_r    <= (kind_r == pmcp_pkg::KIND_WRITE);
    end
  end

endmodule

### sv/protection_mcu_command_port_core.sv
// Each item is latched, then applied or divided, then loaded into the output register.
// A new item is accepted only after the previous answer has been loaded into the output register.
// The 8-step restoring divider, one quotient bit per cycle, handles a nonzero divisor write.
// An item is accepted while the previous answer still waits in the output register.
// Reset is synchronous, active low: divide idle, no table, pointer, dividend, answer and
// region all cleared.
`timescale 1ns / 1ps

module protection_mcu_command_port_core #(
  parameter int TABLE_DEPTH = pmcp_pkg::TABLE_DEPTH_DEF
) (
  input logic         clk,
  input logic         rst_n,
  pmcp_in_if.sink     in_ch,
  pmcp_out_if.source  out_ch,
  pmcp_cfg_if.sink    cfg_ch
);

  pmcp_pkg::pmcp_cmd_t  cmd;
  pmcp_pkg::pmcp_stat_t stat;

  // The region register is always writable.
  assign cfg_ch.ready = 1'b1;

  pmcp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  pmcp_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_kind         (in_ch.kind),
    .in_write_byte   (in_ch.write_byte),
    .cfg_we          (cfg_ch.valid),
    .cfg_region      (cfg_ch.region_variant),
    .out_answer_byte (out_ch.answer_byte),
    .out_irq_request (out_ch.irq_request)
  );

endmodule
